// File: src/pfam_pkg.sv
// ----------------------------------------------------------------------------
// pfam_pkg: shared types and constants of the page frame allocation map
// Request and result word layouts, request codes, sequencer states and the
// fixed geometry of the map words.
// ----------------------------------------------------------------------------
package pfam_pkg;

  localparam int PAGE_W   = 16;   // page numbers are 16 bits wide
  localparam int LIMIT_W  = 17;   // page_limit register width
  localparam int WORD_W   = 32;   // map bits per memory word
  localparam int BIT_W    = 5;    // bit select within a map word
  localparam int APB_AW   = 3;    // byte address of two 32-bit registers
  localparam int APB_DW   = 32;

  localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RST   = 17'h10000;
  localparam logic [PAGE_W-1:0]  SEARCH_START_RST = 16'd256;

  // register index, taken from paddr[2]
  localparam logic REG_PAGE_LIMIT   = 1'b0;
  localparam logic REG_SEARCH_START = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SEARCH  = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef struct packed {
    op_t               operation;
    logic [PAGE_W-1:0] page;
  } in_item_t;

  typedef struct packed {
    logic              granted;
    logic [PAGE_W-1:0] found_page;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SRCH,
    ST_RESP
  } state_t;

endpackage

// File: src/pfam_map_ram.sv
// ----------------------------------------------------------------------------
// pfam_map_ram: used/free bitmap storage
// One write port and one read port, one map word per address, registered
// read data.
// ----------------------------------------------------------------------------
module pfam_map_ram
  import pfam_pkg::*;
#(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/pfam_free_find.sv
// ----------------------------------------------------------------------------
// pfam_free_find: lowest free bit of one map word
// Restrict the word to bits lo_bit..hi_bit and return the lowest clear bit.
// ----------------------------------------------------------------------------
module pfam_free_find
  import pfam_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  input  logic [BIT_W-1:0]  lo_bit,
  input  logic [BIT_W-1:0]  hi_bit,
  output logic              hit,
  output logic [BIT_W-1:0]  idx
);

  logic [WORD_W-1:0] cand;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      cand[b] = !word[b] && (BIT_W'(b) >= lo_bit) && (BIT_W'(b) <= hi_bit);
    end
  end

  // priority pick, lowest bit wins
  always_comb begin
    hit = |cand;
    idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        idx = BIT_W'(b);
      end
    end
  end

endmodule

// File: src/page_frame_allocation_map_unit.sv
// ----------------------------------------------------------------------------
// page_frame_allocation_map_unit: bitmap allocator for physical page frames
// One used/free mark per page frame, with allocate, release and first-free
// search requests and an APB-style register port.
// ----------------------------------------------------------------------------
// The map lives in a single-port-read, single-port-write memory of 32-bit
// words (one bit per page frame, PAGE_FRAMES capped at 65536 pages). After
// reset the block runs a clearing pass that writes one map word per cycle,
// ceil(min(PAGE_FRAMES,65536)/32) words in all (2048 at the default), and
// takes no request until it ends; register writes are taken throughout.
// Allocate and release are a read-modify-write of one map word, read on
// acceptance and written back in ST_MOD before the result goes out from
// ST_RESP. A no-op, an allocate or release of a page at or above the limit,
// and a search over an empty window go from acceptance straight to ST_RESP.
// A search streams map words out of the memory read port at one word per
// cycle through the free-bit finder, from the word holding search_start up
// to the word holding the first free page (at most the whole window up to
// the limit, 2048 words at the default), then hands its result to ST_RESP.
// One request is worked on at a time; a new request is taken as soon as
// the previous result sits in the output register, even if that result has
// not yet been taken. A result that finds the output register still full
// holds the sequencer until that word is taken.
// ----------------------------------------------------------------------------
module page_frame_allocation_map_unit
  import pfam_pkg::*;
#(
  parameter int PAGE_FRAMES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // pages beyond the 16-bit page space are never reachable
  localparam int MAP_PAGES = (PAGE_FRAMES > 65536) ? 65536 : PAGE_FRAMES;
  localparam int DEPTH     = (MAP_PAGES + WORD_W - 1) / WORD_W;
  localparam int ADDR_W    = $clog2(DEPTH);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [LIMIT_W-1:0] page_limit_r;
  logic [PAGE_W-1:0]  search_start_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_limit_r   <= PAGE_LIMIT_RST;
      search_start_r <= SEARCH_START_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_PAGE_LIMIT:   page_limit_r   <= pwdata[LIMIT_W-1:0];
        REG_SEARCH_START: search_start_r <= pwdata[PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PAGE_LIMIT:   prdata = APB_DW'(page_limit_r);
      REG_SEARCH_START: prdata = APB_DW'(search_start_r);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Limit in force and search window bounds
  // --------------------------------------------------------------------------
  logic [LIMIT_W-1:0] eff_lim;
  logic [LIMIT_W-1:0] lim_m1;
  logic [ADDR_W-1:0]  start_w;
  logic [ADDR_W-1:0]  last_w;
  logic               win_empty;

  assign eff_lim   = (page_limit_r > LIMIT_W'(MAP_PAGES)) ? LIMIT_W'(MAP_PAGES)
                                                          : page_limit_r;
  assign lim_m1    = eff_lim - LIMIT_W'(1);
  assign start_w   = search_start_r[BIT_W +: ADDR_W];
  assign last_w    = lim_m1[BIT_W +: ADDR_W];
  assign win_empty = ({1'b0, search_start_r} >= eff_lim);

  // --------------------------------------------------------------------------
  // Map memory and free-bit finder
  // --------------------------------------------------------------------------
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  pfam_map_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [BIT_W-1:0] ff_lo;
  logic [BIT_W-1:0] ff_hi;
  logic             ff_hit;
  logic [BIT_W-1:0] ff_idx;

  pfam_free_find u_find (
    .word   (ram_rdata),
    .lo_bit (ff_lo),
    .hi_bit (ff_hi),
    .hit    (ff_hit),
    .idx    (ff_idx)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t            state_r,     state_nxt;
  logic [ADDR_W-1:0] clr_addr_r,  clr_addr_nxt;
  op_t               op_r,        op_nxt;
  logic [PAGE_W-1:0] page_r,      page_nxt;
  logic [ADDR_W-1:0] scan_addr_r, scan_addr_nxt;
  logic              scan_end_r,  scan_end_nxt;
  logic              chk_v_r,     chk_v_nxt;
  logic [ADDR_W-1:0] chk_w_r,     chk_w_nxt;
  out_item_t         res_r,       res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r,  out_data_nxt;

  logic              bit_used;
  logic [WORD_W-1:0] bit_mask;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign bit_mask = WORD_W'(1) << page_r[BIT_W-1:0];
  assign bit_used = ram_rdata[page_r[BIT_W-1:0]];

  // finder window: trim the first word below search_start, the last at the limit
  assign ff_lo = (chk_w_r == start_w) ? search_start_r[BIT_W-1:0] : '0;
  assign ff_hi = (chk_w_r == last_w)  ? lim_m1[BIT_W-1:0]         : '1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      scan_end_r  <= 1'b0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      scan_end_r  <= scan_end_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    page_r      <= page_nxt;
    scan_addr_r <= scan_addr_nxt;
    chk_w_r     <= chk_w_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    op_nxt        = op_r;
    page_nxt      = page_r;
    scan_addr_nxt = scan_addr_r;
    scan_end_nxt  = scan_end_r;
    chk_v_nxt     = 1'b0;
    chk_w_nxt     = chk_w_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    // drop the held result once it is taken
    out_valid_nxt = out_valid_r && !out_ready;

    ram_we    = 1'b0;
    ram_waddr = page_r[BIT_W +: ADDR_W];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = in_data.page[BIT_W +: ADDR_W];

    unique case (state_r)
      ST_CLEAR: begin
        // sweep the map to all-free, one word a cycle
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_data.operation;
          page_nxt = in_data.page;
          res_nxt  = '0;
          unique case (in_data.operation) inside
            OP_ALLOC, OP_RELEASE: begin
              // fetch the map word now, modify it next cycle
              if ({1'b0, in_data.page} < eff_lim) begin
                ram_re    = 1'b1;
                state_nxt = ST_MOD;
              end else begin
                state_nxt = ST_RESP;
              end
            end
            OP_SEARCH: begin
              if (win_empty) begin
                state_nxt = ST_RESP;
              end else begin
                scan_addr_nxt = start_w;
                scan_end_nxt  = 1'b0;
                state_nxt     = ST_SRCH;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_MOD: begin
        ram_we = 1'b1;
        if (op_r == OP_ALLOC) begin
          ram_wdata = ram_rdata | bit_mask;
          res_nxt.granted = !bit_used;
        end else begin
          ram_wdata = ram_rdata & ~bit_mask;
        end
        state_nxt = ST_RESP;
      end

      ST_SRCH: begin
        // issue the next word while the previous one is checked
        ram_raddr = scan_addr_r;
        if (!scan_end_r) begin
          ram_re        = 1'b1;
          scan_addr_nxt = scan_addr_r + ADDR_W'(1);
          scan_end_nxt  = (scan_addr_r == last_w);
          chk_v_nxt     = 1'b1;
          chk_w_nxt     = scan_addr_r;
        end
        if (chk_v_r) begin
          if (ff_hit) begin
            res_nxt.found_page = PAGE_W'({chk_w_r, ff_idx});
            chk_v_nxt          = 1'b0;
            state_nxt          = ST_RESP;
          end else if (chk_w_r == last_w) begin
            chk_v_nxt = 1'b0;
            state_nxt = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the page frame allocation map unit
// Drives allocate, release, search and no-op request words through the
// valid/ready request channel, predicts every result from a bit-level model
// of the frame map kept here, and checks each result word field by field.
// A directed table covers the register extremes and the corner cases. Random
// phases with fresh register settings follow, with stalls on both channels.
// ----------------------------------------------------------------------------
module tb
  import pfam_pkg::*;
();

  localparam int unsigned N_ITEMS      = 450;
  // Clearing pass plus, per word, a worst-case full-map scan and the longest
  // gaps on both sides, quadrupled.
  localparam int unsigned SCAN_WORDS   = 65536 / WORD_W;
  localparam int unsigned CYCLE_LIMIT  = SCAN_WORDS + 600 * (SCAN_WORDS + 3 + 80) * 4;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned WIN          = 48;   // width of the random page cluster

  // Directed table rows: a request word with a typed-in result, a request
  // word checked against the predictor, or a register write.
  typedef enum logic [1:0] {
    ROW_KNOWN,
    ROW_PRED,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    op_t         op;
    logic [31:0] arg;      // page for request words, value for register writes
    logic        reg_sel;  // register index for register writes
    out_item_t   want;
  } dir_row_t;

  localparam int N_DIR = 32;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_item_t        in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_data;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic            pready;

  // Local copy of the frame map and of the two registers.
  bit                frame_used [65536];
  logic [LIMIT_W-1:0] lim_reg   = PAGE_LIMIT_RST;
  logic [PAGE_W-1:0]  start_reg = SEARCH_START_RST;

  out_item_t    pending_results [$];
  bit           steady = 1'b0;      // no idling on either side while set
  int unsigned  err_cnt = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  stall_left = 0;
  int unsigned  n_words = 0;
  int unsigned  n_counted = 0;
  int unsigned  n_searches = 0;
  int unsigned  n_checked = 0;
  int unsigned  n_grants = 0;
  int unsigned  n_settings = 0;

  dir_row_t dir_tab [N_DIR] = '{
    // reset state: search from page 256 over a free map
    '{ROW_KNOWN, OP_SEARCH,  32'h0000_0000, 1'b0, '{1'b0, 16'd256}},
    '{ROW_KNOWN, OP_ALLOC,   32'd256,       1'b0, '{1'b1, 16'd0}},
    '{ROW_KNOWN, OP_ALLOC,   32'd256,       1'b0, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_SEARCH,  32'h0000_FFFF, 1'b0, '{1'b0, 16'd257}},
    '{ROW_KNOWN, OP_ALLOC,   32'h0000_FFFF, 1'b0, '{1'b1, 16'd0}},
    '{ROW_KNOWN, OP_ALLOC,   32'd0,         1'b0, '{1'b1, 16'd0}},
    '{ROW_KNOWN, OP_RELEASE, 32'd0,         1'b0, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_NOP,     32'h0000_FFFF, 1'b0, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_RELEASE, 32'd256,       1'b0, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_SEARCH,  32'd0,         1'b0, '{1'b0, 16'd256}},
    '{ROW_PRED,  OP_ALLOC,   32'd257,       1'b0, '{1'b0, 16'd0}},
    // no frames at all: everything fails or is dropped
    '{ROW_REG,   OP_NOP,     32'd0,         REG_PAGE_LIMIT, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_ALLOC,   32'd0,         1'b0, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_RELEASE, 32'h0000_FFFF, 1'b0, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_SEARCH,  32'd0,         1'b0, '{1'b0, 16'd0}},
    // limit above the page space acts as 65536; search at the top page
    '{ROW_REG,   OP_NOP,     32'h0001_FFFF, REG_PAGE_LIMIT,   '{1'b0, 16'd0}},
    '{ROW_REG,   OP_NOP,     32'h0000_FFFF, REG_SEARCH_START, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_SEARCH,  32'd0,         1'b0, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_RELEASE, 32'h0000_FFFF, 1'b0, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_SEARCH,  32'd0,         1'b0, '{1'b0, 16'hFFFF}},
    // search from page zero: a free page zero reads the same as none found
    '{ROW_REG,   OP_NOP,     32'd0,         REG_SEARCH_START, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_SEARCH,  32'd0,         1'b0, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_ALLOC,   32'd0,         1'b0, '{1'b1, 16'd0}},
    '{ROW_PRED,  OP_SEARCH,  32'd0,         1'b0, '{1'b0, 16'd0}},
    // two-page window: invalid page at the limit, then a full window
    '{ROW_REG,   OP_NOP,     32'd300,       REG_PAGE_LIMIT,   '{1'b0, 16'd0}},
    '{ROW_REG,   OP_NOP,     32'd298,       REG_SEARCH_START, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_ALLOC,   32'd300,       1'b0, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_ALLOC,   32'd299,       1'b0, '{1'b1, 16'd0}},
    '{ROW_KNOWN, OP_ALLOC,   32'd298,       1'b0, '{1'b1, 16'd0}},
    '{ROW_KNOWN, OP_SEARCH,  32'd0,         1'b0, '{1'b0, 16'd0}},
    // start at the limit: empty window
    '{ROW_REG,   OP_NOP,     32'd300,       REG_SEARCH_START, '{1'b0, 16'd0}},
    '{ROW_KNOWN, OP_SEARCH,  32'd0,         1'b0, '{1'b0, 16'd0}}
  };

  page_frame_allocation_map_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request word to the local map and return its result word.
  function automatic out_item_t predict_outcome(input in_item_t w);
    out_item_t   r;
    int unsigned lim;
    int unsigned p;
    bit          hit;
    r   = '0;
    hit = 1'b0;
    // page numbers are 16 bits, so anything above 65536 is clipped
    lim = (lim_reg > PAGE_LIMIT_RST) ? 32'h1_0000 : int'(lim_reg);
    case (w.operation)
      OP_ALLOC: begin
        if (w.page < lim && !frame_used[w.page]) begin
          frame_used[w.page] = 1'b1;
          r.granted = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (w.page < lim) frame_used[w.page] = 1'b0;
      end
      OP_SEARCH: begin
        for (p = start_reg; p < lim && !hit; p++) begin
          if (!frame_used[p]) begin
            r.found_page = p[PAGE_W-1:0];
            hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Idle length: mostly none, some short, a few long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_failure(input string what, input out_item_t want, input out_item_t got);
    err_cnt++;
    if (err_cnt <= REPORT_MAX)
      $display("tb: %s: expected granted=%0b found=%0d, got granted=%0b found=%0d",
               what, want.granted, want.found_page, got.granted, got.found_page);
  endtask

  // Hold valid and the word until taken, then queue the expected result.
  // Valid stays up after the handshake so a back-to-back word needs only
  // one assignment in that step.
  task automatic send_word(input in_item_t w, input bit known, input out_item_t want);
    int unsigned gap;
    out_item_t   res;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    res = predict_outcome(w);
    pending_results.push_back(known ? want : res);
    n_words++;
    if (w.operation != OP_NOP) n_counted++;
    if (w.operation == OP_SEARCH) n_searches++;
  endtask

  // Drop valid and hold off until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Setup phase, access phase (held until pready), then the bus returns to idle.
  task automatic reg_write(input logic sel, input logic [31:0] val);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {sel, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (sel == REG_PAGE_LIMIT) lim_reg = val[LIMIT_W-1:0];
    else start_reg = val[PAGE_W-1:0];
  endtask

  // Receiver: stall out_ready for random stretches.
  always @(posedge clk) begin
    int unsigned n;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      n = idle_len();
      stall_left <= (n != 0) ? n - 1 : 0;
      out_ready  <= (n == 0);
    end
  end

  // Compare every taken result word with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_failure("result word with nothing pending", '0, out_data);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_data.granted) n_grants++;
        if (out_data.granted !== want.granted || out_data.found_page !== want.found_page)
          note_failure("result mismatch", want, out_data);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results pending",
               cycle_cnt, pending_results.size());
      $display("tb: errors");
      $finish;
    end
  end

  initial begin : stim
    dir_row_t    row;
    in_item_t    w;
    int unsigned r;
    int unsigned lo;
    int unsigned lim_eff;
    int unsigned n_in_phase;
    logic [31:0] new_lim;
    logic [31:0] new_start;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Register rows wait for the map to go idle first; the
    // first request word also waits out the clearing pass through in_ready.
    for (int i = 0; i < N_DIR; i++) begin
      row = dir_tab[i];
      if (row.kind == ROW_REG) begin
        wait_drained();
        reg_write(row.reg_sel, row.arg);
        n_settings++;
      end else begin
        w.operation = row.op;
        w.page      = row.arg[PAGE_W-1:0];
        send_word(w, row.kind == ROW_KNOWN, row.want);
      end
    end

    // Random phases: drain, pick a register setting, then a burst of words
    // clustered just above the search start so the map fills and the search
    // has work to do. The drain before each setting also covers the case of
    // the sender pausing until every result is back.
    while (n_counted < N_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0: begin new_lim = 32'h1_0000; new_start = 32'd256; end
        1: begin new_lim = 32'h1_FFFF; new_start = $urandom_range(0, 65535); end
        2: begin
          new_start = $urandom_range(0, 2000);
          new_lim   = new_start + $urandom_range(1, 40);
        end
        3: begin new_lim = $urandom_range(0, 4096); new_start = 32'd0; end
        4: begin new_lim = $urandom_range(0, 1024); new_start = $urandom_range(0, 1100); end
        default: begin new_lim = 32'h1_0000; new_start = 65535 - $urandom_range(0, 40); end
      endcase
      reg_write(REG_PAGE_LIMIT, new_lim);
      reg_write(REG_SEARCH_START, new_start);
      n_settings++;
      steady = ($urandom_range(0, 3) == 0);
      lim_eff = (lim_reg > PAGE_LIMIT_RST) ? 32'h1_0000 : int'(lim_reg);
      n_in_phase = $urandom_range(30, 70);
      repeat (n_in_phase) begin
        r = $urandom_range(0, 99);
        if (r < 45)      w.operation = OP_ALLOC;
        else if (r < 70) w.operation = OP_RELEASE;
        else if (r < 95) w.operation = OP_SEARCH;
        else             w.operation = OP_NOP;
        r = $urandom_range(0, 99);
        if (r < 70) begin
          lo = start_reg + $urandom_range(0, WIN - 1);
          w.page = lo[PAGE_W-1:0];
        end else if (r < 80) begin
          // straddle the limit: last valid pages and the first invalid ones
          lo = lim_eff + $urandom_range(0, 3) - 2;
          w.page = lo[PAGE_W-1:0];
        end else begin
          w.page = $urandom_range(0, 65535);
        end
        send_word(w, 1'b0, '0);
      end
    end

    wait_drained();
    steady = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d request words sent (%0d searches) across %0d register settings",
             n_words, n_searches, n_settings);
    $display("tb: %0d results checked, %0d granted, %0d failures",
             n_checked, n_grants, err_cnt);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
src/pfam_pkg.sv
src/pfam_map_ram.sv
src/pfam_free_find.sv
src/page_frame_allocation_map_unit.sv
bench/tb.sv
